// ----- hw/rtl/clr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_BITS = 12;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 2;
    localparam int COLOR_W    = 16;
    localparam int DIM_W      = 11;

    // stream payload widths, rounded up to whole bytes
    localparam int S_FIELD_W  = 4 * COORD_BITS + COLOR_W;
    localparam int S_DATA_W   = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W  = 2 * COORD_BITS + COLOR_W;
    localparam int M_DATA_W   = ((M_FIELD_W + 7) / 8) * 8;

    // command queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // register select (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd240;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd320;

    // classified command, already in major/minor axes
    typedef struct packed {
        logic                         action;
        logic                         steep;
        logic signed [COORD_BITS-1:0] major_pos;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [COORD_BITS-1:0] minor_pos;
        logic                         minor_dir_down;
        logic [DELTA_W-1:0]           major_delta;
        logic [DELTA_W-1:0]           minor_delta;
        logic [COLOR_W-1:0]           color;
    } line_cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } screen_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clr_front import clr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_action,
    input  wire logic [COORD_BITS-1:0] in_sx,
    input  wire logic [COORD_BITS-1:0] in_sy,
    input  wire logic [COORD_BITS-1:0] in_ex,
    input  wire logic [COORD_BITS-1:0] in_ey,
    input  wire logic [COLOR_W-1:0]    in_color,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output line_cmd_t                  push_cmd
);

    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_action_reg;
    logic                         s1_steep_reg;
    logic signed [COORD_BITS-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic [DELTA_W-1:0]           s1_dx_reg, s1_dy_reg;
    logic [COLOR_W-1:0]           s1_color_reg;

    logic signed [DELTA_W-1:0] diff_x, diff_y;
    logic [DELTA_W-1:0]        abs_x, abs_y;
    logic                      accept;

    // absolute deltas; these do not change under the swaps below
    always_comb begin
        diff_x = DELTA_W'($signed(in_sx)) - DELTA_W'($signed(in_ex));
        diff_y = DELTA_W'($signed(in_sy)) - DELTA_W'($signed(in_ey));
        abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
    end

    assign in_ready = !s1_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (push_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_action_reg <= in_action;
            s1_steep_reg  <= abs_y > abs_x;
            s1_ax_reg     <= in_sx;
            s1_ay_reg     <= in_sy;
            s1_bx_reg     <= in_ex;
            s1_by_reg     <= in_ey;
            s1_dx_reg     <= abs_x;
            s1_dy_reg     <= abs_y;
            s1_color_reg  <= in_color;
        end
    end

    // axis swap and low-to-high ordering
    logic signed [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
    logic                         swap;

    always_comb begin
        a_maj = s1_steep_reg ? s1_ay_reg : s1_ax_reg;
        a_min = s1_steep_reg ? s1_ax_reg : s1_ay_reg;
        b_maj = s1_steep_reg ? s1_by_reg : s1_bx_reg;
        b_min = s1_steep_reg ? s1_bx_reg : s1_by_reg;
        swap  = a_maj > b_maj;

        push_cmd.action         = s1_action_reg;
        push_cmd.steep          = s1_steep_reg;
        push_cmd.major_pos      = swap ? b_maj : a_maj;
        push_cmd.major_end      = swap ? a_maj : b_maj;
        push_cmd.minor_pos      = swap ? b_min : a_min;
        push_cmd.minor_dir_down = swap ? (b_min < a_min) : (a_min < b_min);
        push_cmd.major_delta    = s1_steep_reg ? s1_dy_reg : s1_dx_reg;
        push_cmd.minor_delta    = s1_steep_reg ? s1_dx_reg : s1_dy_reg;
        push_cmd.color          = s1_color_reg;
    end

    assign push_valid = s1_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/clr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clr_queue import clr_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire line_cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop,
    output line_cmd_t      pop_cmd,
    output logic [QCNT_W-1:0] level
);

    line_cmd_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign level      = count_reg;

    // pointer wrap at depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clr_back import clr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire screen_cfg_t           scr,
    input  wire logic                  cmd_valid,
    output logic                       cmd_pop,
    input  wire line_cmd_t             cmd,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_BITS-1:0]      out_x,
    output logic [COORD_BITS-1:0]      out_y,
    output logic [COLOR_W-1:0]         out_color,
    output logic                       out_visible,
    output logic                       out_last
);

    localparam int CMP_W = COORD_BITS + DIM_W + 1;

    // line walker state
    logic                         active_reg, active_next;
    logic                         steep_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg, major_end_reg, minor_pos_reg;
    logic                         dir_down_reg;
    logic [DELTA_W-1:0]           major_delta_reg, minor_delta_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic [COLOR_W-1:0]           color_reg;

    // output word register
    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic [COLOR_W-1:0]    m_color_reg;
    logic                  m_vis_reg, m_last_reg;

    logic                         out_free, is_start, emit;
    logic signed [COORD_BITS-1:0] px, py;
    logic                         vis, last;
    logic signed [ERR_W-1:0]      err_sub, err_add;

    assign out_free = !m_valid_reg || out_ready;
    assign is_start = cmd.action == ACT_START;
    assign cmd_pop  = cmd_valid && (is_start || !active_reg || out_free);
    assign emit     = cmd_valid && !is_start && active_reg && out_free;

    // current pixel in screen axes and its clip test
    always_comb begin
        px   = steep_reg ? minor_pos_reg : major_pos_reg;
        py   = steep_reg ? major_pos_reg : minor_pos_reg;
        vis  = !px[COORD_BITS-1] && !py[COORD_BITS-1]
            && (CMP_W'(px) < CMP_W'(scr.width))
            && (CMP_W'(py) < CMP_W'(scr.height));
        last = major_pos_reg >= major_end_reg;
    end

    // error update: subtract minor delta, add major delta back on underflow
    always_comb begin
        err_sub = err_reg - $signed(ERR_W'(minor_delta_reg));
        err_add = err_sub + $signed(ERR_W'(major_delta_reg));
    end

    always_comb begin
        active_next = active_reg;
        if (cmd_pop && is_start) begin
            active_next = 1'b1;
        end else if (emit && last) begin
            active_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // load on start, advance on each emitted pixel
    always_ff @(posedge aclk) begin
        if (cmd_pop && is_start) begin
            steep_reg       <= cmd.steep;
            major_pos_reg   <= cmd.major_pos;
            major_end_reg   <= cmd.major_end;
            minor_pos_reg   <= cmd.minor_pos;
            dir_down_reg    <= cmd.minor_dir_down;
            major_delta_reg <= cmd.major_delta;
            minor_delta_reg <= cmd.minor_delta;
            err_reg         <= $signed(ERR_W'(cmd.major_delta >> 1));
            color_reg       <= cmd.color;
        end else if (emit && !last) begin
            major_pos_reg <= major_pos_reg + 1'b1;
            if (err_sub[ERR_W-1]) begin
                minor_pos_reg <= minor_pos_reg + {{(COORD_BITS-1){~dir_down_reg}}, 1'b1};
                err_reg       <= err_add;
            end else begin
                err_reg <= err_sub;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_x_reg     <= px;
            m_y_reg     <= py;
            m_color_reg <= color_reg;
            m_vis_reg   <= vis;
            m_last_reg  <= last;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_x       = m_x_reg;
    assign out_y       = m_y_reg;
    assign out_color   = m_color_reg;
    assign out_visible = m_vis_reg;
    assign out_last    = m_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/clipped_line_rasterizer_top.sv -----
// Channel   Dir  Handshake          Word
// s_        in   s_tvalid/s_tready  s_tdata: endpoints + color, s_tuser: action
// m_        out  m_tvalid/m_tready  m_tdata: pixel x, y, color, m_tuser: visible,
//                                   m_tlast: last pixel of line
// cfg       in   APB psel/penable   screen_width @0x0, screen_height @0x4
//
// One word is accepted per cycle unless the queue is full, and one pixel leaves per
// cycle unless m_ stalls; a start word is consumed by the walker and yields no pixel.
// A step word passes the front register, the queue and the output register on its
// way to its pixel; the walker's error update (subtract, add back) sets the rate.
// A four-entry command queue lets the front keep accepting while m_ stalls.
// Reset is synchronous, active low, clears the handshake flags and line-active flag,
// and sets the screen registers to 240 x 320; datapath registers keep their value.
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_rasterizer_top import clr_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // start_x, start_y, end_x, end_y, line_color (low to high)
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // action
    input  wire logic                s_tuser,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pixel_x, pixel_y, pixel_color (low to high)
    output logic [M_DATA_W-1:0]      m_tdata,
    // visible
    output logic                     m_tuser,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int CB = COORD_BITS;

    // configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                width_reg <= pwdata[DIM_W-1:0];
            end else begin
                height_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    // paddr[1:0] is byte lane only and is not decoded
    always_comb begin
        prdata = {{(32-DIM_W){1'b0}}, width_reg};
        if (paddr[2] == REG_HEIGHT && paddr[1:0] == 2'b00) begin
            prdata = {{(32-DIM_W){1'b0}}, height_reg};
        end else if (paddr[2] == REG_HEIGHT) begin
            prdata = {{(32-DIM_W){1'b0}}, height_reg};
        end
    end

    screen_cfg_t scr;
    assign scr.width  = width_reg;
    assign scr.height = height_reg;

    // front: accept and classify
    logic          push_valid, push_ready;
    line_cmd_t     push_cmd;

    clr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_sx      (s_tdata[CB-1:0]),
        .in_sy      (s_tdata[2*CB-1:CB]),
        .in_ex      (s_tdata[3*CB-1:2*CB]),
        .in_ey      (s_tdata[4*CB-1:3*CB]),
        .in_color   (s_tdata[4*CB+COLOR_W-1:4*CB]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    logic              q_valid, q_pop;
    line_cmd_t         q_cmd;
    logic [QCNT_W-1:0] q_level;

    clr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd),
        .level      (q_level)
    );

    // back: line walker and output register
    logic [CB-1:0]      px, py;
    logic [COLOR_W-1:0] pcolor;

    clr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scr         (scr),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .cmd         (q_cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (px),
        .out_y       (py),
        .out_color   (pcolor),
        .out_visible (m_tuser),
        .out_last    (m_tlast)
    );

    assign m_tdata = M_DATA_W'({pcolor, py, px});

    // queue never overfills
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QCNT_W'(QDEPTH))
        else $error("command queue level above depth");

    // input stalls only when the front holds a word the queue cannot take
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> push_valid && !push_ready)
        else $error("input stalled without full queue");

    // a visible pixel has non-negative coordinates
    a_visible_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[CB-1] && !m_tdata[2*CB-1])
        else $error("visible pixel with negative coordinate");

    // queue pops only what it holds
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_level != '0)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

// ----- dv/clipped_line_rasterizer_top_tb.sv -----
`timescale 1ns / 1ps

module clipped_line_rasterizer_top_tb import clr_pkg::*; ();

    logic                aclk;
    logic                aresetn;
    // start_x, start_y, end_x, end_y, line_color (low to high)
    logic [S_DATA_W-1:0] s_tdata;
    // action
    logic                s_tuser;
    logic                s_tvalid;
    logic                s_tready;
    // pixel_x, pixel_y, pixel_color (low to high)
    logic [M_DATA_W-1:0] m_tdata;
    // visible
    logic                m_tuser;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // traffic shaping, shared by sender and receiver
    logic no_idle;
    int   rx_hold;
    int   words_sent;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COLOR_W-1:0]           color;
        logic                         vis;
        logic                         last;
    } pixel_t;

    // Bresenham walk predictor plus queue of pixels still owed by the block
    class line_walk_model;
        logic [DIM_W-1:0]             width;
        logic [DIM_W-1:0]             height;
        logic                         active;
        logic                         steep;
        logic                         minor_up;
        logic signed [COORD_BITS-1:0] major_pos;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [COORD_BITS-1:0] minor_pos;
        logic [DELTA_W-1:0]           major_delta;
        logic [DELTA_W-1:0]           minor_delta;
        logic signed [ERR_W-1:0]      err_acc;
        logic [COLOR_W-1:0]           color;
        pixel_t                       expected_pixels[$];
        int                           errors;

        function new();
            width       = WIDTH_RST;
            height      = HEIGHT_RST;
            active      = 1'b0;
            steep       = 1'b0;
            minor_up    = 1'b0;
            major_pos   = '0;
            major_end   = '0;
            minor_pos   = '0;
            major_delta = '0;
            minor_delta = '0;
            err_acc     = '0;
            color       = '0;
            errors      = 0;
        endfunction

        function int mag(int v);
            return (v < 0) ? -v : v;
        endfunction

        // one accepted input word
        function void note_word(logic act, logic [S_DATA_W-1:0] data);
            int     ax, ay, bx, by;
            int     a_maj, a_min, b_maj, b_min, t;
            pixel_t px;
            ax = int'($signed(data[0 +: COORD_BITS]));
            ay = int'($signed(data[COORD_BITS +: COORD_BITS]));
            bx = int'($signed(data[2*COORD_BITS +: COORD_BITS]));
            by = int'($signed(data[3*COORD_BITS +: COORD_BITS]));
            if (act == ACT_START) begin
                steep = mag(ay - by) > mag(ax - bx);
                if (steep) begin
                    a_maj = ay; a_min = ax; b_maj = by; b_min = bx;
                end else begin
                    a_maj = ax; a_min = ay; b_maj = bx; b_min = by;
                end
                // walk the major axis low to high
                if (a_maj > b_maj) begin
                    t = a_maj; a_maj = b_maj; b_maj = t;
                    t = a_min; a_min = b_min; b_min = t;
                end
                major_pos   = COORD_BITS'(a_maj);
                major_end   = COORD_BITS'(b_maj);
                minor_pos   = COORD_BITS'(a_min);
                minor_up    = a_min < b_min;
                major_delta = DELTA_W'(b_maj - a_maj);
                minor_delta = DELTA_W'(mag(a_min - b_min));
                err_acc     = $signed(ERR_W'(major_delta >> 1));
                color       = data[4*COORD_BITS +: COLOR_W];
                active      = 1'b1;
            end else if (active) begin
                px.x     = steep ? minor_pos : major_pos;
                px.y     = steep ? major_pos : minor_pos;
                px.color = color;
                px.vis   = int'(px.x) >= 0 && int'(px.y) >= 0 &&
                           int'(px.x) < int'(width) && int'(px.y) < int'(height);
                px.last  = major_pos >= major_end;
                expected_pixels.push_back(px);
                if (px.last) begin
                    active = 1'b0;
                end else begin
                    err_acc = err_acc - $signed({1'b0, minor_delta});
                    if (err_acc < 0) begin
                        minor_pos = minor_up ? COORD_BITS'(minor_pos + 1)
                                             : COORD_BITS'(minor_pos - 1);
                        err_acc   = err_acc + $signed({1'b0, major_delta});
                    end
                    major_pos = COORD_BITS'(major_pos + 1);
                end
            end
        endfunction

        // one accepted output word against the oldest owed pixel
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", got.x, got.y);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.x !== want.x) begin
                $error("pixel_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.color !== want.color) begin
                $error("pixel_color: expected %h, got %h", want.color, got.color);
                errors++;
            end
            if (got.vis !== want.vis) begin
                $error("visible: expected %0b, got %0b", want.vis, got.vis);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_pixel: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    line_walk_model sb;

    clipped_line_rasterizer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // half near the visible area, half anywhere
    function automatic int pick_coord(int limit);
        if ($urandom_range(0, 1))
            return clamp_coord(int'($urandom_range(0, limit + 32)) - 16);
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int pick_offset(int span);
        int v;
        v = int'($urandom_range(0, span));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // inputs change at the falling edge; returns at a falling edge
    task automatic send_word(input logic act, input logic [S_DATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_step();
        send_word(ACT_STEP, {$urandom, $urandom});
    endtask

    // start word followed by a number of step words
    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [COLOR_W-1:0] col, input int steps);
        logic [S_DATA_W-1:0] w;
        w = '0;
        w[0 +: COORD_BITS]            = sx[COORD_BITS-1:0];
        w[COORD_BITS +: COORD_BITS]   = sy[COORD_BITS-1:0];
        w[2*COORD_BITS +: COORD_BITS] = ex[COORD_BITS-1:0];
        w[3*COORD_BITS +: COORD_BITS] = ey[COORD_BITS-1:0];
        w[4*COORD_BITS +: COLOR_W]    = col;
        send_word(ACT_START, w);
        repeat (steps) send_step();
        words_sent += steps + 1;
    endtask

    task automatic random_line();
        int sx, sy, ex, ey, span, n, r, ax, ay;
        r  = $urandom_range(0, 99);
        sx = pick_coord(int'(sb.width));
        sy = pick_coord(int'(sb.height));
        span = $urandom_range(0, 99);
        span = (span < 85) ? 8 : (span < 98) ? 60 : 400;
        ex = clamp_coord(sx + pick_offset(span));
        ey = clamp_coord(sy + pick_offset(span));
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        n  = ((ax > ay) ? ax : ay) + 1;
        // cut short: the next start drops the rest
        if (r < 12) n = $urandom_range(0, n - 1);
        send_line(sx, sy, ex, ey, 16'($urandom), n);
        // stray steps, ignored once the line has ended
        if (r >= 94) repeat ($urandom_range(1, 3)) send_step();
    endtask

    // APB write: setup then access cycle
    task automatic cfg_write(input logic reg_sel, input logic [DIM_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_sel == REG_WIDTH) sb.width = value;
        else sb.height = value;
    endtask

    // wait out owed pixels plus pipeline latency
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_tready   = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // input and output monitors
    always @(posedge aclk) begin
        pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x     = m_tdata[0 +: COORD_BITS];
            got.y     = m_tdata[COORD_BITS +: COORD_BITS];
            got.color = m_tdata[2*COORD_BITS +: COLOR_W];
            got.vis   = m_tuser;
            got.last  = m_tlast;
            sb.check_pixel(got);
        end
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(s_tuser, s_tdata);
    end

    // main sequence
    initial begin
        int phase;
        logic [DIM_W-1:0] w, h;
        sb         = new();
        no_idle    = 1'b0;
        rx_hold    = 0;
        words_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = ACT_STEP;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: step with no line, single point then a stray step
        send_step();
        send_line(5, 7, 5, 7, 16'h1234, 1);
        send_step();
        // steep with reversed ends, then a diagonal going down
        send_line(1, 0, 0, 3, 16'hA5A5, 4);
        send_line(0, 3, 3, 0, 16'h5A5A, 4);
        // flat minor crossing x = 0
        send_line(-2, 5, 1, 5, 16'h0F0F, 4);
        // coordinate extremes, each cut short by the next start
        send_line(-2048, 2047, 2047, -2048, 16'hFFFF, 2);
        send_line(2047, 2047, 2047, -2048, 16'h0000, 2);
        // across the default right and bottom edges
        send_line(238, 319, 241, 321, 16'hF00F, 4);

        for (phase = 0; phase < 7; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: begin w = 11'd0;    h = 11'd0;    end
                    2: begin w = 11'd2047; h = 11'd2047; end
                    3: begin w = 11'd1;    h = 11'd1;    end
                    4: begin w = 11'd0;    h = 11'd2047; end
                    5: begin w = 11'd2047; h = 11'd0;    end
                    default: begin
                        w = 11'($urandom_range(1, 2047));
                        h = 11'($urandom_range(1, 2047));
                    end
                endcase
                cfg_write(REG_WIDTH, w);
                cfg_write(REG_HEIGHT, h);
            end
            no_idle = (phase == 3);
            // receiver holds off while a long line is pushed back to back
            if (phase == 1) begin
                no_idle = 1'b1;
                rx_hold = 150;
                send_line(10, 20, 100, 40, 16'hC3C3, 91);
                no_idle = 1'b0;
            end
            while (words_sent < (phase + 1) * 260) random_line();
        end

        drain();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
